// ----- design/fdq_pkg.sv -----
package fdq_pkg;

  localparam int unsigned Depth    = 16;
  localparam int unsigned IdxW     = $clog2(Depth);
  localparam int unsigned CntW     = $clog2(Depth + 1);
  localparam int unsigned PtsW     = 48;
  localparam int unsigned WordW    = 32;
  localparam int unsigned EntryW   = 3 * WordW + PtsW;

  localparam logic [2:0] CmdPush   = 3'd0;
  localparam logic [2:0] CmdPop    = 3'd1;
  localparam logic [2:0] CmdPeek   = 3'd2;
  localparam logic [2:0] CmdLookup = 3'd3;
  localparam logic [2:0] CmdClear  = 3'd4;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StFull     = 2'd1;
  localparam logic [1:0] StEmpty    = 2'd2;
  localparam logic [1:0] StNotFound = 2'd3;

  localparam logic [0:0] RegCapacity = 1'b0;

  typedef struct packed {
    logic [2:0]        cmd;
    logic              drop_oldest;
    logic [WordW-1:0]  frame_handle;
    logic [WordW-1:0]  frame_size;
    logic [WordW-1:0]  frame_info;
    logic [PtsW-1:0]   pts;
    logic [PtsW-1:0]   arrive_ts;
    logic [PtsW-1:0]   seek_pts;
    logic [PtsW-1:0]   tolerance;
  } fdq_req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              repeated;
    logic              dropped_oldest;
    logic [WordW-1:0]  out_handle;
    logic [WordW-1:0]  out_size;
    logic [WordW-1:0]  out_info;
    logic [PtsW-1:0]   out_pts;
    logic [4:0]        queue_count;
    logic [WordW-1:0]  dropped_total;
    logic [WordW-1:0]  late_total;
    logic [WordW-1:0]  repeated_total;
    logic [PtsW-1:0]   max_latency;
  } fdq_rsp_t;

  typedef struct packed {
    logic [WordW-1:0] handle;
    logic [WordW-1:0] size;
    logic [WordW-1:0] info;
    logic [PtsW-1:0]  pts;
  } fdq_entry_t;

  function automatic logic [WordW-1:0] sat_inc(input logic [WordW-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

endpackage

// ----- design/frame_descriptor_queue.sv -----
// Frame descriptor queue: a ring of 16 descriptors (handle, size, info, PTS)
// with push (refuse or drop-oldest when full), pop (repeats the last popped
// frame when empty), peek, PTS lookup and clear. One command is taken at a
// time; in_ready_o is low while a command is worked. Push, pop, peek, clear
// and unknown commands go through a registered descriptor memory read
// (StRead) and a finish step (StDone) before the result is valid.
// Lookup walks the queue from the oldest entry through one shared
// distance/compare unit, one entry per cycle after the registered read,
// and stops at the first entry within tolerance of the seek PTS, or with
// StNotFound once all entries are visited. The result sits in an output
// register; the next command is taken the cycle after it is consumed, so a
// simple command passes through StIdle, StRead, StDone and StOut.
// Capacity (APB, paddr[2] low, 5 bits, reset 16): 0 acts as 1, above 16 as 16.
module frame_descriptor_queue import fdq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  fdq_req_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output fdq_rsp_t    out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StRead = 5'b00010,  // memory read in flight
    StWalk = 5'b00100,  // lookup compare of one entry
    StDone = 5'b01000,  // finish non-lookup command
    StOut  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  fdq_entry_t mem_q [Depth];
  fdq_entry_t rd_q;
  logic [IdxW-1:0] rd_addr;
  logic            wr_en;
  logic [IdxW-1:0] wr_addr;
  fdq_entry_t      wr_data;

  fdq_req_t   req_q;
  fdq_rsp_t   rsp_q, rsp_d;
  logic [4:0] cap_q;
  logic [IdxW-1:0] head_q, head_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] walk_q, walk_d;  // lookup position from head
  logic            last_valid_q, last_valid_d;
  fdq_entry_t      last_q, last_d;
  logic [WordW-1:0] drop_cnt_q, drop_cnt_d, late_cnt_q, late_cnt_d;
  logic [WordW-1:0] rep_cnt_q, rep_cnt_d;
  logic [PtsW-1:0]  peak_q, peak_d;

  // APB: pready tied high, writes land on setup+access
  assign pready = 1'b1;
  assign prdata = {27'd0, cap_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= 5'd16;
    end else if (psel && penable && pwrite && paddr[2] == RegCapacity) begin
      cap_q <= pwdata[4:0];
    end
  end

  logic [CntW-1:0] eff_cap;
  always_comb begin
    if (cap_q == '0) eff_cap = CntW'(1);
    else if (cap_q > 5'(Depth)) eff_cap = CntW'(Depth);
    else eff_cap = CntW'(cap_q);
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);
  assign out_data_o  = rsp_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    rd_q <= mem_q[rd_addr];
  end

  // shared distance/compare unit
  logic [PtsW-1:0] pts_gap;
  logic            match;
  always_comb begin
    pts_gap = (rd_q.pts > req_q.seek_pts) ? rd_q.pts - req_q.seek_pts
                                          : req_q.seek_pts - rd_q.pts;
    match   = pts_gap <= req_q.tolerance;
  end

  logic            full;
  logic [PtsW-1:0] lat;
  assign full = count_q >= eff_cap;
  assign lat  = req_q.pts - req_q.arrive_ts;

  always_comb begin
    state_d      = state_q;
    rsp_d        = rsp_q;
    head_d       = head_q;
    count_d      = count_q;
    walk_d       = walk_q;
    last_valid_d = last_valid_q;
    last_d       = last_q;
    drop_cnt_d   = drop_cnt_q;
    late_cnt_d   = late_cnt_q;
    rep_cnt_d    = rep_cnt_q;
    peak_d       = peak_q;
    wr_en        = 1'b0;
    wr_addr      = head_q + IdxW'(count_q);
    wr_data      = '{handle: req_q.frame_handle, size: req_q.frame_size,
                     info: req_q.frame_info, pts: req_q.pts};
    // walk prefetches the next entry; otherwise read the entry at walk_q
    rd_addr      = (state_q == StWalk) ? head_q + IdxW'(walk_q) + IdxW'(1)
                                       : head_q + IdxW'(walk_q);
    case (state_q)
      StIdle: begin
        walk_d = '0;
        if (in_valid_i) state_d = StRead;
      end
      StRead: begin
        rsp_d = '0;
        if (req_q.cmd == CmdLookup) begin
          state_d = StWalk;
        end else begin
          state_d = StDone;
        end
      end
      StWalk: begin
        if (walk_q >= count_q) begin
          rsp_d.status = StNotFound;
          state_d = StOut;
        end else if (match) begin
          rsp_d.out_handle = rd_q.handle;
          rsp_d.out_size   = rd_q.size;
          rsp_d.out_info   = rd_q.info;
          rsp_d.out_pts    = rd_q.pts;
          state_d = StOut;
        end else begin
          walk_d = walk_q + 1'b1;
        end
      end
      StDone: begin
        state_d = StOut;
        case (req_q.cmd)
          CmdPush: begin
            if (full && !req_q.drop_oldest) begin
              rsp_d.status = StFull;
            end else begin
              if (full && count_q != '0) begin
                head_d  = head_q + 1'b1;
                wr_addr = head_q + IdxW'(count_q);
                count_d = count_q - 1'b1;
                drop_cnt_d = sat_inc(drop_cnt_q);
                rsp_d.dropped_oldest = 1'b1;
              end
              if (count_d < CntW'(Depth)) begin
                wr_en   = 1'b1;
                count_d = count_d + 1'b1;
                if (req_q.arrive_ts > req_q.pts) late_cnt_d = sat_inc(late_cnt_q);
                if (req_q.pts > req_q.arrive_ts && lat > peak_q) peak_d = lat;
              end
            end
          end
          CmdPop: begin
            if (count_q != '0) begin
              rsp_d.out_handle = rd_q.handle;
              rsp_d.out_size   = rd_q.size;
              rsp_d.out_info   = rd_q.info;
              rsp_d.out_pts    = rd_q.pts;
              last_d       = rd_q;
              last_valid_d = 1'b1;
              head_d       = head_q + 1'b1;
              count_d      = count_q - 1'b1;
            end else if (last_valid_q) begin
              rsp_d.repeated   = 1'b1;
              rsp_d.out_handle = last_q.handle;
              rsp_d.out_size   = last_q.size;
              rsp_d.out_info   = last_q.info;
              rsp_d.out_pts    = last_q.pts;
              rep_cnt_d = sat_inc(rep_cnt_q);
            end else begin
              rsp_d.status = StEmpty;
            end
          end
          CmdPeek: begin
            if (count_q != '0) begin
              rsp_d.out_handle = rd_q.handle;
              rsp_d.out_size   = rd_q.size;
              rsp_d.out_info   = rd_q.info;
              rsp_d.out_pts    = rd_q.pts;
            end else begin
              rsp_d.status = StEmpty;
            end
          end
          CmdClear: begin
            count_d      = '0;
            head_d       = '0;
            last_valid_d = 1'b0;
            last_d       = '0;
          end
          default: ;
        endcase
      end
      StOut: begin
        if (out_ready_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
    if (state_d == StOut && state_q != StOut) begin
      rsp_d.queue_count    = 5'(count_d);
      rsp_d.dropped_total  = drop_cnt_d;
      rsp_d.late_total     = late_cnt_d;
      rsp_d.repeated_total = rep_cnt_d;
      rsp_d.max_latency    = peak_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) req_q <= in_data_i;
    rsp_q <= rsp_d;
    last_q <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      head_q       <= '0;
      count_q      <= '0;
      walk_q       <= '0;
      last_valid_q <= 1'b0;
      drop_cnt_q   <= '0;
      late_cnt_q   <= '0;
      rep_cnt_q    <= '0;
      peak_q       <= '0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      count_q      <= count_d;
      walk_q       <= walk_d;
      last_valid_q <= last_valid_d;
      drop_cnt_q   <= drop_cnt_d;
      late_cnt_q   <= late_cnt_d;
      rep_cnt_q    <= rep_cnt_d;
      peak_q       <= peak_d;
    end
  end

endmodule
